>>> hw/rtl/fpsc_pkg.sv
package fpsc_pkg;

    // Angle format: a quarter turn is 2^QUARTER_BITS units.
    localparam int QUARTER_BITS = 13;
    localparam int ANG_W        = 15;
    // Wide enough for the angle plus a quarter turn and both quadrant bits.
    localparam int EXT_W        = (ANG_W + 1 > QUARTER_BITS + 2) ? ANG_W + 1 : QUARTER_BITS + 2;
    // Folded position runs from zero up to a full quarter inclusive.
    localparam int POS_W        = QUARTER_BITS + 1;

    // Interpolation weight and table geometry.
    localparam int W_BITS   = 12;
    localparam int SEG_BITS = 7;
    localparam int SEG_W    = SEG_BITS + 1;
    localparam int SC_W     = SEG_BITS + W_BITS;
    localparam int LUT_W    = 16;
    localparam int LUT_N    = 129;
    localparam int VAL_W    = 17;
    localparam int PROD_W   = VAL_W + W_BITS + 1;

    // Control that travels with each beat through the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
    } t_ctl;

    // Cosine over the first quarter in 127 segments (128 entries), plus a closing entry.
    localparam logic [LUT_W-1:0] COS_LUT [0:LUT_N-1] = '{
        16'h8000, 16'h7ffd, 16'h7ff5, 16'h7fe9, 16'h7fd7, 16'h7fc1, 16'h7fa5, 16'h7f85,
        16'h7f5f, 16'h7f35, 16'h7f05, 16'h7ed1, 16'h7e97, 16'h7e59, 16'h7e15, 16'h7dcd,
        16'h7d80, 16'h7d2e, 16'h7cd7, 16'h7c7b, 16'h7c1a, 16'h7bb4, 16'h7b4a, 16'h7adb,
        16'h7a66, 16'h79ed, 16'h7970, 16'h78ed, 16'h7866, 16'h77da, 16'h7749, 16'h76b4,
        16'h761a, 16'h757c, 16'h74d9, 16'h7431, 16'h7385, 16'h72d4, 16'h721e, 16'h7165,
        16'h70a6, 16'h6fe4, 16'h6f1d, 16'h6e51, 16'h6d82, 16'h6cae, 16'h6bd5, 16'h6af9,
        16'h6a18, 16'h6934, 16'h684b, 16'h675e, 16'h666d, 16'h6578, 16'h647e, 16'h6382,
        16'h6281, 16'h617c, 16'h6073, 16'h5f67, 16'h5e57, 16'h5d43, 16'h5c2c, 16'h5b11,
        16'h59f2, 16'h58d0, 16'h57ab, 16'h5682, 16'h5555, 16'h5425, 16'h52f2, 16'h51bc,
        16'h5083, 16'h4f46, 16'h4e06, 16'h4cc3, 16'h4b7e, 16'h4a35, 16'h48e9, 16'h479b,
        16'h4649, 16'h44f5, 16'h439e, 16'h4245, 16'h40e9, 16'h3f8a, 16'h3e29, 16'h3cc6,
        16'h3b60, 16'h39f8, 16'h388d, 16'h3721, 16'h35b2, 16'h3441, 16'h32ce, 16'h3159,
        16'h2fe2, 16'h2e69, 16'h2cef, 16'h2b72, 16'h29f4, 16'h2874, 16'h26f3, 16'h2570,
        16'h23ec, 16'h2266, 16'h20df, 16'h1f57, 16'h1dcd, 16'h1c43, 16'h1ab7, 16'h192a,
        16'h179c, 16'h160d, 16'h147e, 16'h12ed, 16'h115c, 16'h0fca, 16'h0e38, 16'h0ca5,
        16'h0b11, 16'h097d, 16'h07e9, 16'h0654, 16'h04bf, 16'h032a, 16'h0195, 16'h0000,
        16'h0000
    };

endpackage

>>> hw/rtl/fpsc_fold.sv
module fpsc_fold (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_command,
    input  logic [fpsc_pkg::ANG_W-1:0]  i_angle,
    output fpsc_pkg::t_ctl              o_ctl,
    output logic [fpsc_pkg::POS_W-1:0]  o_pos
);
    import fpsc_pkg::*;

    localparam logic [EXT_W-1:0] QUARTER_EXT = EXT_W'(1) << QUARTER_BITS;
    localparam logic [POS_W-1:0] QUARTER_POS = POS_W'(1) << QUARTER_BITS;

    logic [EXT_W-1:0]        ext;
    logic [1:0]              quad;
    logic [POS_W-1:0]        pos_raw;
    t_ctl                    n_ctl;
    logic [POS_W-1:0]        n_pos;
    t_ctl                    r_ctl;
    logic [POS_W-1:0]        r_pos;

    // Sine is the cosine of the angle plus a quarter turn, negated.
    always_comb begin
        ext     = EXT_W'(i_angle) + (i_command ? QUARTER_EXT : '0);
        quad    = ext[QUARTER_BITS+1:QUARTER_BITS];
        pos_raw = {1'b0, ext[QUARTER_BITS-1:0]};
        // Odd quadrants mirror the position within the quarter.
        n_pos   = quad[0] ? (QUARTER_POS - pos_raw) : pos_raw;
        n_ctl.valid = i_valid;
        n_ctl.neg   = (quad[0] ^ quad[1]) ^ i_command;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_pos <= n_pos;
    end

    assign o_ctl = r_ctl;
    assign o_pos = r_pos;

endmodule

>>> hw/rtl/fpsc_scale.sv
module fpsc_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpsc_pkg::t_ctl              i_ctl,
    input  logic [fpsc_pkg::POS_W-1:0]  i_pos,
    output fpsc_pkg::t_ctl              o_ctl,
    output logic [fpsc_pkg::SC_W-1:0]   o_scaled
);
    import fpsc_pkg::*;

    localparam int M_W   = POS_W + SEG_BITS;
    localparam int SUM_W = M_W + W_BITS + 1;
    localparam logic [SUM_W-1:0] ROUND_UP = (SUM_W'(1) << QUARTER_BITS) - SUM_W'(1);

    logic [M_W-1:0]   times_seg;
    logic [SUM_W-1:0] sum;
    logic [SC_W-1:0]  n_scaled;
    t_ctl             r_ctl;
    logic [SC_W-1:0]  r_scaled;

    // Position times 127 segments times the weight unit, divided by the
    // quarter turn with rounding up.
    always_comb begin
        times_seg = (M_W'(i_pos) << SEG_BITS) - M_W'(i_pos);
        sum       = (SUM_W'(times_seg) << W_BITS) + ROUND_UP;
        n_scaled  = SC_W'(sum >> QUARTER_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_scaled <= n_scaled;
    end

    assign o_ctl    = r_ctl;
    assign o_scaled = r_scaled;

endmodule

>>> hw/rtl/fpsc_lut.sv
module fpsc_lut (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpsc_pkg::t_ctl              i_ctl,
    input  logic [fpsc_pkg::SC_W-1:0]   i_scaled,
    output fpsc_pkg::t_ctl              o_ctl,
    output logic [fpsc_pkg::LUT_W-1:0]  o_lo,
    output logic [fpsc_pkg::LUT_W-1:0]  o_hi,
    output logic [fpsc_pkg::W_BITS-1:0] o_frac
);
    import fpsc_pkg::*;

    logic [SEG_W-1:0]  idx_lo;
    logic [SEG_W-1:0]  idx_hi;
    t_ctl              r_ctl;
    logic [LUT_W-1:0]  r_lo;
    logic [LUT_W-1:0]  r_hi;
    logic [W_BITS-1:0] r_frac;

    // The integer part never exceeds 127, so both neighbors stay in range.
    assign idx_lo = {1'b0, i_scaled[SC_W-1:W_BITS]};
    assign idx_hi = idx_lo + SEG_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_lo   <= COS_LUT[idx_lo];
        r_hi   <= COS_LUT[idx_hi];
        r_frac <= i_scaled[W_BITS-1:0];
    end

    assign o_ctl  = r_ctl;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_frac = r_frac;

endmodule

>>> hw/rtl/fpsc_interp.sv
module fpsc_interp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpsc_pkg::t_ctl              i_ctl,
    input  logic [fpsc_pkg::LUT_W-1:0]  i_lo,
    input  logic [fpsc_pkg::LUT_W-1:0]  i_hi,
    input  logic [fpsc_pkg::W_BITS-1:0] i_frac,
    output logic                        o_valid,
    output logic [fpsc_pkg::VAL_W-1:0]  o_value
);
    import fpsc_pkg::*;

    logic signed [VAL_W-1:0]  diff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] sum;
    logic [VAL_W-1:0]         mag;
    logic [VAL_W-1:0]         n_value;
    t_ctl                     r_ctl;
    logic signed [PROD_W-1:0] r_prod;
    logic [LUT_W-1:0]         r_lo;
    logic                     r_valid;
    logic [VAL_W-1:0]         r_value;

    // lo*(1-w) + hi*w is formed as lo + (hi-lo)*w with one multiplier.
    always_comb begin
        diff   = $signed({1'b0, i_hi}) - $signed({1'b0, i_lo});
        n_prod = PROD_W'(diff * $signed({1'b0, i_frac}));
    end

    // Add the base back, truncate the weight bits and apply the sign.
    always_comb begin
        sum     = $signed({{(PROD_W-LUT_W-W_BITS){1'b0}}, r_lo, {W_BITS{1'b0}}}) + r_prod;
        mag     = sum[VAL_W+W_BITS-1:W_BITS];
        n_value = r_ctl.neg ? (VAL_W'(0) - mag) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ctl   <= i_ctl;
            r_valid <= r_ctl.valid;
        end
        r_prod  <= n_prod;
        r_lo    <= i_lo;
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

>>> hw/rtl/fixed_point_sine_cosine.sv
// Each beat is registered through every stage listed below, in order, before
// its result reaches the ports.
// Throughput: one beat per cycle; the five register stages (fold, scale,
// table read, multiply, sum) each take a new beat on every clock.
// busy is always low and the result strobe cannot be held off.
// Synchronous active-low reset clears the stage control bits only.
module fixed_point_sine_cosine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [fpsc_pkg::ANG_W-1:0]  i_angle,
    output logic                        o_valid,
    output logic [fpsc_pkg::VAL_W-1:0]  o_value
);
    import fpsc_pkg::*;

    t_ctl              ctl_fold;
    t_ctl              ctl_scale;
    t_ctl              ctl_lut;
    logic [POS_W-1:0]  pos;
    logic [SC_W-1:0]   scaled;
    logic [LUT_W-1:0]  lut_lo;
    logic [LUT_W-1:0]  lut_hi;
    logic [W_BITS-1:0] frac;

    // Every stage advances each cycle, so a new beat is always welcome.
    assign busy = 1'b0;

    fpsc_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_command (i_command),
        .i_angle   (i_angle),
        .o_ctl     (ctl_fold),
        .o_pos     (pos)
    );

    fpsc_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_fold),
        .i_pos    (pos),
        .o_ctl    (ctl_scale),
        .o_scaled (scaled)
    );

    fpsc_lut u_lut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_scale),
        .i_scaled (scaled),
        .o_ctl    (ctl_lut),
        .o_lo     (lut_lo),
        .o_hi     (lut_hi),
        .o_frac   (frac)
    );

    fpsc_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_lut),
        .i_lo    (lut_lo),
        .i_hi    (lut_hi),
        .i_frac  (frac),
        .o_valid (o_valid),
        .o_value (o_value)
    );

endmodule
